[design/wssr_pkg.sv]
// ----------------------------------------------------------------------------
// wssr_pkg
// shared types and constants of the windowed sample statistics recorder
// ----------------------------------------------------------------------------
package wssr_pkg;

    localparam int unsigned CODE_W    = 12;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned DEPTH_DEF = 128;

    localparam logic [CODE_W-1:0] CODE_FULL = '1;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] sample_a;
        logic [CODE_W-1:0] sample_b;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] record_count;
        logic [CODE_W-1:0]  max_a;
        logic [CODE_W-1:0]  min_a;
        logic [CODE_W-1:0]  mean_a;
        logic [CODE_W-1:0]  max_b;
        logic [CODE_W-1:0]  min_b;
        logic [CODE_W-1:0]  mean_b;
    } t_out_item;

endpackage

[design/wssr_if.sv]
// ----------------------------------------------------------------------------
// wssr_in_if / wssr_out_if
// valid/ready channels carrying one input transaction or one result
// ----------------------------------------------------------------------------
interface wssr_in_if;
    import wssr_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wssr_out_if;
    import wssr_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/wssr_mem.sv]
// ----------------------------------------------------------------------------
// wssr_mem
// sample pair store, one write port and one registered read port
// ----------------------------------------------------------------------------
module wssr_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/wssr_div.sv]
// ----------------------------------------------------------------------------
// wssr_div
// restoring divider, one quotient bit per cycle, quotient known to fit a code
// ----------------------------------------------------------------------------
module wssr_div #(
    parameter int unsigned CW = 8,
    parameter int unsigned SW = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SW-1:0]              i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [wssr_pkg::CODE_W-1:0] o_quot
);
    import wssr_pkg::*;

    localparam int unsigned STEP_W = $clog2(CODE_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [CW-1:0]       r_rem;
    logic [CW-1:0]       r_div;
    logic [CODE_W-1:0]   r_low;
    logic [CODE_W-1:0]   r_quot;

    logic [CW:0]         trial;
    logic                fits;

    // sum < 4096 * count, so the high part already sits below the divisor
    assign trial = {r_rem, r_low[CODE_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CODE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= CW'(i_dividend[SW-1:CODE_W]);
            r_low  <= i_dividend[CODE_W-1:0];
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? CW'(trial - {1'b0, r_div}) : CW'(trial);
            r_low  <= {r_low[CODE_W-2:0], 1'b0};
            r_quot <= {r_quot[CODE_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[design/windowed_sample_stats_recorder_core.sv]
// ----------------------------------------------------------------------------
// windowed_sample_stats_recorder_core
// min, max and mean of a sliding window of sample pairs held in one memory
// ----------------------------------------------------------------------------
// A record transaction writes its sample pair into the window memory and then
// walks every valid entry through the single read port, one entry per cycle,
// before two bit-serial dividers form the means. A record or a clear raises the
// result valid in the same cycle in which the input becomes ready again; a
// clear skips the scan and the division. One transaction is in work at a time,
// and the result sits in an output register so a new transaction is taken
// while it waits.
module windowed_sample_stats_recorder_core #(
    parameter int unsigned DEPTH = wssr_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wssr_in_if.sink         i_in,
    wssr_out_if.source      o_out
);
    import wssr_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CODE_W + AW;
    localparam int unsigned DW = 2 * CODE_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wr_pos, n_wr_pos;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_issue, n_issue;
    logic            r_rd_pend, n_rd_pend;
    logic            r_out_vld, n_out_vld;

    logic [CODE_W-1:0] r_max_a, r_min_a, r_max_b, r_min_b;
    logic [SW-1:0]     r_sum_a, r_sum_b;
    t_out_item         r_res;
    t_out_item         r_out;

    logic              in_acc;
    logic              mem_we;
    logic [DW-1:0]     mem_rdata;
    logic [CODE_W-1:0] rd_a, rd_b;
    logic              scan_end;
    logic              div_done_a, div_done_b;
    logic [CODE_W-1:0] quot_a, quot_b;
    logic              out_load;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign mem_we     = in_acc && (i_in.data.op == OP_RECORD);
    assign rd_a       = mem_rdata[DW-1:CODE_W];
    assign rd_b       = mem_rdata[CODE_W-1:0];
    assign scan_end   = (r_state == ST_SCAN) && (r_issue == r_cnt) && !r_rd_pend;
    assign out_load   = (r_state == ST_DONE) && (!r_out_vld || o_out.ready);

    wssr_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_pos),
        .i_wdata ({i_in.data.sample_a, i_in.data.sample_b}),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    wssr_div #(.CW(CW), .SW(SW)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_end),
        .i_dividend (r_sum_a),
        .i_divisor  (r_cnt),
        .o_done     (div_done_a),
        .o_quot     (quot_a)
    );

    wssr_div #(.CW(CW), .SW(SW)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_end),
        .i_dividend (r_sum_b),
        .i_divisor  (r_cnt),
        .o_done     (div_done_b),
        .o_quot     (quot_b)
    );

    always_comb begin
        n_state   = r_state;
        n_wr_pos  = r_wr_pos;
        n_cnt     = r_cnt;
        n_issue   = r_issue;
        n_rd_pend = 1'b0;
        n_out_vld = r_out_vld;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.op == OP_CLEAR) begin
                        n_wr_pos = '0;
                        n_cnt    = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_wr_pos = (r_wr_pos == AW'(DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
                        if (r_cnt != CW'(DEPTH)) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_issue = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // one read per cycle, data shows up in the next cycle
                if (r_issue != r_cnt) begin
                    n_issue   = r_issue + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (scan_end) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done_a && div_done_b) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr_pos  <= '0;
            r_cnt     <= '0;
            r_issue   <= '0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pos  <= n_wr_pos;
            r_cnt     <= n_cnt;
            r_issue   <= n_issue;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= n_out_vld;
        end
    end

    // accumulators and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_max_a <= '0;
            r_min_a <= CODE_FULL;
            r_sum_a <= '0;
            r_max_b <= '0;
            r_min_b <= CODE_FULL;
            r_sum_b <= '0;
            r_res   <= '0;
        end else if ((r_state == ST_SCAN) && r_rd_pend) begin
            if (rd_a > r_max_a) r_max_a <= rd_a;
            if (rd_a < r_min_a) r_min_a <= rd_a;
            if (rd_b > r_max_b) r_max_b <= rd_b;
            if (rd_b < r_min_b) r_min_b <= rd_b;
            r_sum_a <= r_sum_a + SW'(rd_a);
            r_sum_b <= r_sum_b + SW'(rd_b);
        end else if ((r_state == ST_DIV) && div_done_a) begin
            r_res.record_count <= COUNT_W'(r_cnt);
            r_res.max_a        <= r_max_a;
            r_res.min_a        <= r_min_a;
            r_res.mean_a       <= quot_a;
            r_res.max_b        <= r_max_b;
            r_res.min_b        <= r_min_b;
            r_res.mean_b       <= quot_b;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

[design/wssr_chk.sv]
// ----------------------------------------------------------------------------
// wssr_chk
// port level checks of the recorder, bound to the top level
// ----------------------------------------------------------------------------
module wssr_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input wssr_pkg::t_out_item  i_out_data
);
    import wssr_pkg::*;

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transaction taken while busy");

    // mean of channel a lies between its extremes
    a_order_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.min_a <= i_out_data.mean_a) &&
                        (i_out_data.mean_a <= i_out_data.max_a))
        else $error("channel a statistics out of order");

    // mean of channel b lies between its extremes
    a_order_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.min_b <= i_out_data.mean_b) &&
                        (i_out_data.mean_b <= i_out_data.max_b))
        else $error("channel b statistics out of order");

endmodule

bind windowed_sample_stats_recorder_core wssr_chk u_wssr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
